>>> sv/scanline_flash_trigger_top_defines.svh
// ----------------------------------------------------------------------------
// scanline flash trigger assertion macros
// shared property templates, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef SCANLINE_FLASH_TRIGGER_TOP_DEFINES_SVH
`define SCANLINE_FLASH_TRIGGER_TOP_DEFINES_SVH

// same-cycle implication
`define SFT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanline flash trigger: same-cycle check failed");

// next-cycle implication
`define SFT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanline flash trigger: next-cycle check failed");

`endif

>>> sv/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// shared widths, register indexes and divider handshake types of the
// scanline flash trigger
// ----------------------------------------------------------------------------
package sft_pkg;

  // geometry of the sampled rows
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 8192;
  localparam int PIXEL_BITS  = 14;

  // field widths
  localparam int ROW_W     = 4;
  localparam int COL_W     = 13;
  localparam int PIX_W     = PIXEL_BITS;
  localparam int THR_W     = 15;
  localparam int HOLD_W    = 10;
  localparam int SUM_W     = 31;
  localparam int COUNT_W   = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // line store
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // accumulator limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register reset values
  localparam logic [THR_W-1:0]  ABS_THR_RESET = THR_W'(10000);
  localparam logic [THR_W-1:0]  REL_THR_RESET = THR_W'(1000);
  localparam logic [HOLD_W-1:0] HOLD_RESET    = HOLD_W'(10);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_ENABLE  = 3'd0,
    REG_ABS_ENABLE    = 3'd1,
    REG_REL_ENABLE    = 3'd2,
    REG_ABS_THRESHOLD = 3'd3,
    REG_REL_THRESHOLD = 3'd4,
    REG_HOLD_FRAMES   = 3'd5
  } cfg_reg_t;

  // average divider request and response
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/sft_avg_div.sv
// ----------------------------------------------------------------------------
// sft_avg_div
// restoring divider for the frame average, one quotient bit per cycle;
// the quotient never exceeds the largest pixel value, so only PIX_W steps
// are run; a zero divisor gives a zero quotient
// ----------------------------------------------------------------------------
module sft_avg_div (
  input  logic              clk,
  input  logic              rst,
  input  sft_pkg::div_req_t req,
  output sft_pkg::div_rsp_t rsp
);
  import sft_pkg::*;

  localparam int STEP_W = (PIX_W > 1) ? $clog2(PIX_W) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PIX_W - 1);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            dstate;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic [SUM_W-1:0]   dsh;
  logic [PIX_W-1:0]   quo;
  logic               done;

  logic [COUNT_W:0]   trial;
  logic               ge;
  logic [COUNT_W-1:0] rem_next;

  // one trial subtraction
  always_comb begin
    trial    = {rem, dsh[SUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? COUNT_W'(trial - {1'b0, dvs}) : COUNT_W'(trial);
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (req.start) begin
            quo <= '0;
            if (req.divisor == '0) begin
              done <= 1'b1;
            end else begin
              rem    <= COUNT_W'(req.dividend >> PIX_W);
              dsh    <= req.dividend << (SUM_W - PIX_W);
              dvs    <= req.divisor;
              step   <= '0;
              dstate <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem  <= rem_next;
          dsh  <= dsh << 1;
          quo  <= {quo[PIX_W-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            dstate <= D_IDLE;
            done   <= 1'b1;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> sv/scanline_flash_trigger_top.sv
// ----------------------------------------------------------------------------
// scanline_flash_trigger_top
// lightning trigger on a few sampled sensor rows: per-frame brightness peak,
// average and frame-to-frame difference peak, with a post-trigger hold
// ----------------------------------------------------------------------------
// After reset the line store is swept to zero, one entry per cycle, over all
// 131072 entries (MAX_ROWS * MAX_COLUMNS); input items stall during the sweep
// while register writes are taken at any time. A pixel item is accepted in
// S_IDLE and, with the block and difference detection on and the address in
// range, also passes S_RMW, because the single-port line store is read in
// the accept cycle and written back in the next. An item with frame_end set
// passes S_FEND, which starts the average divider, S_DIV, which awaits the
// PIXEL_BITS (14) divider steps and captures the quotient, and S_EMIT, which
// loads the result register; a frame with no counted pixel skips the divider
// steps. With the block disabled a frame end goes straight to the result
// register. A result waiting in the output register does not hold up pixel
// items; only the next frame end waits for the output register to free up.
// ----------------------------------------------------------------------------
`include "scanline_flash_trigger_top_defines.svh"

module scanline_flash_trigger_top (
  input  logic                          clk,
  input  logic                          rst,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sft_pkg::CFG_DAT_W-1:0] cfg_data,
  // pixel items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sft_pkg::ROW_W-1:0]     row_slot,
  input  logic [sft_pkg::COL_W-1:0]     column,
  input  logic [sft_pkg::PIX_W-1:0]     sample,
  input  logic                          frame_end,
  // frame results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          skip_frame,
  output logic                          recording,
  output logic                          abs_hit,
  output logic                          rel_hit,
  output logic [sft_pkg::PIX_W-1:0]     abs_peak_out,
  output logic [sft_pkg::PIX_W-1:0]     abs_average,
  output logic [sft_pkg::PIX_W-1:0]     rel_peak_out
);
  import sft_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RMW, S_FEND, S_DIV, S_EMIT
  } state_t;

  // config registers
  logic              block_enable;
  logic              abs_enable;
  logic              rel_enable;
  logic [THR_W-1:0]  abs_threshold;
  logic [THR_W-1:0]  rel_threshold;
  logic [HOLD_W-1:0] hold_frames;

  // control
  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  logic              item_en;
  logic              last_reg;
  logic [ADDR_W-1:0] addr_reg;
  logic [PIX_W-1:0]  pix_reg;

  // frame accumulators and trigger state
  logic [SUM_W-1:0]   abs_sum;
  logic [PIX_W-1:0]   abs_peak;
  logic [PIX_W-1:0]   rel_peak;
  logic [COUNT_W-1:0] pixel_count;
  logic               record_flag;
  logic [HOLD_W-1:0]  hold_count;
  logic [PIX_W-1:0]   avg_reg;

  // line store
  logic [PIX_W-1:0]  line_mem [STORE_DEPTH];
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [PIX_W-1:0]  mem_rdata;

  // combinational helpers
  logic              accept;
  logic              in_range;
  logic              rel_path;
  logic [ADDR_W-1:0] in_addr;
  logic [SUM_W:0]    sum_try;
  logic              sum_ok;
  logic [PIX_W-1:0]  diff;
  logic              out_load;
  logic              abs_hit_c;
  logic              rel_hit_c;
  logic              record_next;
  logic [HOLD_W-1:0] hold_next;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // register writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enable  <= 1'b0;
      abs_enable    <= 1'b0;
      rel_enable    <= 1'b1;
      abs_threshold <= ABS_THR_RESET;
      rel_threshold <= REL_THR_RESET;
      hold_frames   <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLOCK_ENABLE:  block_enable  <= cfg_data[0];
        REG_ABS_ENABLE:    abs_enable    <= cfg_data[0];
        REG_REL_ENABLE:    rel_enable    <= cfg_data[0];
        REG_ABS_THRESHOLD: abs_threshold <= cfg_data[THR_W-1:0];
        REG_REL_THRESHOLD: rel_threshold <= cfg_data[THR_W-1:0];
        REG_HOLD_FRAMES:   hold_frames   <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake and line store address
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(row_slot) < MAX_ROWS) && (32'(column) < MAX_COLUMNS);
  assign in_addr  = ADDR_W'(32'(row_slot) * MAX_COLUMNS + 32'(column));
  assign rel_path = block_enable && rel_enable && in_range;

  // sum limit check for the average
  assign sum_try = {1'b0, abs_sum} + (SUM_W + 1)'(sample);
  assign sum_ok  = (pixel_count != COUNT_MAX) && !sum_try[SUM_W];

  // absolute difference against the previous frame
  assign diff = (pix_reg >= mem_rdata) ? (pix_reg - mem_rdata) : (mem_rdata - pix_reg);

  // trigger decision at frame end
  assign out_load  = !out_valid || !out_stall;
  assign abs_hit_c = abs_enable && ({1'b0, abs_peak} > abs_threshold);
  assign rel_hit_c = rel_enable && ({1'b0, rel_peak} > rel_threshold);

  always_comb begin
    record_next = record_flag;
    hold_next   = hold_count;
    if (abs_hit_c || rel_hit_c) begin
      record_next = 1'b1;
      hold_next   = '0;
    end else if (record_flag) begin
      if (hold_count < hold_frames) begin
        hold_next = hold_count + 1'b1;
      end else begin
        record_next = 1'b0;
      end
    end
  end

  // line store ports: sweep writes zero, read-modify-write writes the pixel
  assign mem_re    = accept && rel_path;
  assign mem_we    = (state == S_CLEAR) || (state == S_RMW);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr_reg;
  assign mem_wdata = (state == S_CLEAR) ? '0 : pix_reg;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= line_mem[in_addr];
    end
  end

  // average divider
  assign div_req.start    = (state == S_FEND);
  assign div_req.dividend = abs_sum;
  assign div_req.divisor  = pixel_count;

  sft_avg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer, item capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit step sets out_valid itself
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_en  <= block_enable;
            last_reg <= frame_end;
            addr_reg <= in_addr;
            pix_reg  <= sample;
            if (!block_enable) begin
              if (frame_end) begin
                state <= S_EMIT;
              end
            end else if (rel_path) begin
              state <= S_RMW;
            end else if (frame_end) begin
              state <= S_FEND;
            end
          end
        end
        S_RMW: begin
          state <= last_reg ? S_FEND : S_IDLE;
        end
        S_FEND: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            avg_reg <= div_rsp.quotient;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (item_en) begin
              skip_frame   <= !record_next;
              recording    <= record_next;
              abs_hit      <= abs_hit_c;
              rel_hit      <= rel_hit_c;
              abs_peak_out <= abs_enable ? abs_peak : '0;
              abs_average  <= abs_enable ? avg_reg : '0;
              rel_peak_out <= rel_enable ? rel_peak : '0;
            end else begin
              skip_frame   <= 1'b0;
              recording    <= record_flag;
              abs_hit      <= 1'b0;
              rel_hit      <= 1'b0;
              abs_peak_out <= '0;
              abs_average  <= '0;
              rel_peak_out <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // frame accumulators and trigger state
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum     <= '0;
      abs_peak    <= '0;
      rel_peak    <= '0;
      pixel_count <= '0;
      record_flag <= 1'b0;
      hold_count  <= '0;
    end else begin
      if (accept && block_enable && abs_enable) begin
        if (sample > abs_peak) begin
          abs_peak <= sample;
        end
        if (sum_ok) begin
          abs_sum     <= sum_try[SUM_W-1:0];
          pixel_count <= pixel_count + 1'b1;
        end
      end
      if (state == S_RMW && diff > rel_peak) begin
        rel_peak <= diff;
      end
      if (state == S_EMIT && out_load && item_en) begin
        record_flag <= record_next;
        hold_count  <= hold_next;
        abs_sum     <= '0;
        abs_peak    <= '0;
        rel_peak    <= '0;
        pixel_count <= '0;
      end
    end
  end

  // checks
  `SFT_ASSERT_IMP(a_count_sum, pixel_count == '0, abs_sum == '0)
  `SFT_ASSERT_IMP(a_port_excl, mem_we, !mem_re)
  `SFT_ASSERT_NEXT(a_frame_clear, state == S_EMIT && out_load && item_en, pixel_count == '0 && abs_peak == '0 && rel_peak == '0)

endmodule
